[rtl/section_table_address_translator_assert.svh]
// Assertion macros for the section table address translator.
// Used by section_table_address_translator.sv; needs no other file.
`ifndef SECTION_TABLE_ADDRESS_TRANSLATOR_ASSERT_SVH
`define SECTION_TABLE_ADDRESS_TRANSLATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define STAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/stat_pkg.sv]
// Shared types and codes of the section table address translator.
// Used by stat_alu, stat_table and the top level; depends on nothing.
package stat_pkg;

	// Values of the action field.
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_XLATE = 1'b1;

	// Register indexes, as decoded from paddr[2].
	localparam logic REG_SECTION_COUNT = 1'b0;
	localparam logic REG_IMAGE_BASE    = 1'b1;

	// Translation modes; the two remaining codes are invalid.
	typedef enum logic [2:0] {
		MODE_RVA_TO_OFF,
		MODE_RVA_TO_VA,
		MODE_OFF_TO_RVA,
		MODE_OFF_TO_VA,
		MODE_VA_TO_RVA,
		MODE_VA_TO_OFF
	} stat_mode_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} stat_alu_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PREP,
		ST_SCAN,
		ST_FIN1,
		ST_FIN2,
		ST_REPLY
	} stat_state_t;

	// One section table entry.
	typedef struct packed {
		logic [31:0] virtual_start;
		logic [31:0] raw_size;
		logic [31:0] raw_start;
	} stat_entry_t;

	// Table port control from the sequencer.
	typedef struct packed {
		logic we;
		logic re;
	} stat_tbl_ctl_t;

	typedef struct packed {
		logic        action;
		logic [2:0]  mode;
		logic [31:0] address;
		logic [3:0]  entry_index;
		logic [31:0] entry_virtual_start;
		logic [31:0] entry_raw_size;
		logic [31:0] entry_raw_start;
	} stat_item_t;

	typedef struct packed {
		logic [31:0] translated;
		logic        found;
	} stat_result_t;

endpackage

[rtl/stat_alu.sv]
// Shared 33-bit add/subtract unit of the section table address translator.
// Depends on stat_pkg.
module stat_alu (
	input  logic [31:0]           a,
	input  logic [31:0]           b,
	input  stat_pkg::stat_alu_op_t op,
	output logic [32:0]           sum
);
	import stat_pkg::*;

	// Bit 32 is the carry of an add, or the borrow of a subtract (a < b).
	always_comb begin
		unique case (op)
			ALU_SUB: sum = {1'b0, a} - {1'b0, b};
			default: sum = {1'b0, a} + {1'b0, b};
		endcase
	end

endmodule

[rtl/stat_table.sv]
// Section table storage: one write port, one read port with registered data.
// Depends on stat_pkg.
module stat_table #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                    clk,
	input  stat_pkg::stat_tbl_ctl_t ctl,
	input  logic [AW-1:0]           waddr,
	input  stat_pkg::stat_entry_t   wdata,
	input  logic [AW-1:0]           raddr,
	output stat_pkg::stat_entry_t   rdata
);
	import stat_pkg::*;

	stat_entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[waddr] <= wdata;
		end
		if (ctl.re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/section_table_address_translator.sv]
// Top level of the section table address translator: sequencer, registers, APB port.
// Depends on stat_pkg, stat_alu, stat_table and section_table_address_translator_assert.svh.
//
// The block holds a table of section entries (virtual start, raw size, raw
// file start) and converts 32-bit addresses between RVA, VA and file offset.
// A command transfer is taken when start is high and busy is low; each command
// gives exactly one result, shown on result for the single cycle in which done
// is high. The receiver cannot stall that result, so it must capture it in
// that cycle. A load command goes through the load state to the reply state.
// A translate command passes through a setup state, then examines one table
// slot per cycle in slot order. Slot 0 is always examined, and the walk goes
// on up to the active count. A hit forms the result in a finishing state, and
// the modes that add the image base take a second finishing state for that. A
// miss answers right after the last slot. The pace of the walk is set by the
// single table read port and the one shared adder, which it uses once per
// slot. An invalid mode goes from the setup state straight to the reply. The
// user must write registers through the APB port only while the block is
// idle; the block itself does not enforce this.
`include "section_table_address_translator_assert.svh"

module section_table_address_translator #(
	parameter int MAX_SECTIONS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// command channel
	input  logic                   start,
	output logic                   busy,
	input  stat_pkg::stat_item_t   item,
	// result channel
	output logic                   done,
	output stat_pkg::stat_result_t result
);
	import stat_pkg::*;

	// Table address width, slot counter width (holds MAX_SECTIONS itself), and
	// the width used for count compares (at least the 5-bit register).
	localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CW = $clog2(MAX_SECTIONS + 1);
	localparam int NW = (CW > 5) ? CW : 5;

	// Configuration registers.
	logic [4:0]  section_count_q;
	logic [31:0] image_base_q;

	// Sequencer and datapath registers.
	stat_state_t state_q, state_d;
	stat_item_t  item_q;
	logic [31:0] src_q;      // source address, a VA source already moved to an RVA
	logic [31:0] diff_q;     // offset of the address inside the hit section
	logic [31:0] base_q;     // start of the hit section in the target space
	logic [31:0] res_q;
	logic        found_q;
	logic        use_src_q;  // result is the source address itself
	logic [CW-1:0] idx_q;    // slot whose entry sits on the table read data

	// Control from the output decode.
	stat_tbl_ctl_t tbl_ctl;
	stat_alu_op_t  alu_op;
	logic [31:0]   alu_a, alu_b;
	logic [32:0]   alu_sum;
	logic [AW-1:0] tbl_raddr;
	stat_entry_t   tbl_rdata;
	stat_entry_t   tbl_wdata;

	// Mode decode.
	logic by_raw, va_src, pass_src, add_base, bad_mode;

	// Slot walk status.
	logic [NW-1:0] active_n;
	logic [CW-1:0] idx_next;
	logic [31:0]   lo;
	logic          borrow, hdr_hit, sec_hit, last_slot, any_hit, load_ok;

	//------------------------------------------------------------------
	// Configuration port. Register 0 is the section count, register 1 the
	// image base; paddr[2] selects between them.
	//------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_count_q <= 5'd0;
			image_base_q    <= 32'd0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_SECTION_COUNT: section_count_q <= pwdata[4:0];
				default:           image_base_q    <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SECTION_COUNT: prdata = {27'd0, section_count_q};
			default:           prdata = image_base_q;
		endcase
	end

	//------------------------------------------------------------------
	// Mode decode. File-offset sources search by raw start; VA sources first
	// subtract the image base; RVA-to-VA and VA-to-RVA keep the source value
	// on a hit; modes with a VA target add the image base at the end.
	//------------------------------------------------------------------
	always_comb begin
		by_raw   = 1'b0;
		va_src   = 1'b0;
		pass_src = 1'b0;
		add_base = 1'b0;
		bad_mode = 1'b0;
		unique case (item_q.mode)
			MODE_RVA_TO_OFF: ;
			MODE_RVA_TO_VA: begin
				pass_src = 1'b1;
				add_base = 1'b1;
			end
			MODE_OFF_TO_RVA: by_raw = 1'b1;
			MODE_OFF_TO_VA: begin
				by_raw   = 1'b1;
				add_base = 1'b1;
			end
			MODE_VA_TO_RVA: begin
				va_src   = 1'b1;
				pass_src = 1'b1;
			end
			MODE_VA_TO_OFF: va_src = 1'b1;
			default: bad_mode = 1'b1;
		endcase
	end

	//------------------------------------------------------------------
	// Slot walk. The shared unit subtracts the section start from the source
	// address: a borrow means the address lies below the start, otherwise the
	// difference is the offset into the section, and the section contains the
	// address when that offset is below the raw size. This is the unwrapped
	// end compare. At slot 0 a borrow means the address is in the header.
	//------------------------------------------------------------------
	assign active_n = (NW'(section_count_q) > NW'(MAX_SECTIONS)) ?
		NW'(MAX_SECTIONS) : NW'(section_count_q);
	assign idx_next = idx_q + CW'(1);
	assign lo       = by_raw ? tbl_rdata.raw_start : tbl_rdata.virtual_start;
	assign borrow   = alu_sum[32];
	assign hdr_hit  = (idx_q == '0) && borrow;
	assign sec_hit  = (NW'(idx_q) < active_n) && !borrow
		&& (alu_sum[31:0] < tbl_rdata.raw_size);
	assign any_hit  = hdr_hit || sec_hit;
	assign last_slot = ((NW + 1)'(idx_next)) >= ((NW + 1)'(active_n));
	assign load_ok  = ({28'd0, item_q.entry_index} < 32'(MAX_SECTIONS));

	//------------------------------------------------------------------
	// Sequencer: next state.
	//------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (item.action == ACT_LOAD) ? ST_LOAD : ST_PREP;
				end
			end
			ST_LOAD: state_d = ST_REPLY;
			ST_PREP: state_d = bad_mode ? ST_REPLY : ST_SCAN;
			ST_SCAN: begin
				priority if (any_hit) begin
					state_d = ST_FIN1;
				end else if (last_slot) begin
					state_d = ST_REPLY;
				end
			end
			ST_FIN1: state_d = add_base ? ST_FIN2 : ST_REPLY;
			ST_FIN2: state_d = ST_REPLY;
			ST_REPLY: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	//------------------------------------------------------------------
	// Sequencer: table port and shared unit operands for each step.
	//------------------------------------------------------------------
	always_comb begin
		tbl_ctl   = '0;
		tbl_raddr = '0;
		alu_a     = src_q;
		alu_b     = lo;
		alu_op    = ALU_SUB;
		unique case (state_q)
			ST_LOAD: tbl_ctl.we = load_ok;
			ST_PREP: begin
				// Fetch slot 0 and move a VA source down to an RVA.
				tbl_ctl.re = 1'b1;
				alu_a      = item_q.address;
				alu_b      = image_base_q;
			end
			ST_SCAN: begin
				// Compare against the current slot, fetch the next one.
				tbl_ctl.re = 1'b1;
				tbl_raddr  = idx_next[AW-1:0];
			end
			ST_FIN1: begin
				alu_a  = diff_q;
				alu_b  = base_q;
				alu_op = ALU_ADD;
			end
			ST_FIN2: begin
				alu_a  = res_q;
				alu_b  = image_base_q;
				alu_op = ALU_ADD;
			end
			default: ;
		endcase
	end

	assign tbl_wdata.virtual_start = item_q.entry_virtual_start;
	assign tbl_wdata.raw_size      = item_q.entry_raw_size;
	assign tbl_wdata.raw_start     = item_q.entry_raw_start;

	stat_alu u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.op (alu_op),
		.sum(alu_sum)
	);

	stat_table #(
		.DEPTH(MAX_SECTIONS),
		.AW   (AW)
	) u_table (
		.clk  (clk),
		.ctl  (tbl_ctl),
		.waddr(AW'(item_q.entry_index)),
		.wdata(tbl_wdata),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	//------------------------------------------------------------------
	// State register.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	//------------------------------------------------------------------
	// Datapath registers.
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_q <= item;
				end
			end
			ST_LOAD: begin
				res_q   <= 32'd0;
				found_q <= load_ok;
			end
			ST_PREP: begin
				src_q   <= va_src ? alu_sum[31:0] : item_q.address;
				idx_q   <= '0;
				res_q   <= 32'd0;
				found_q <= 1'b0;
			end
			ST_SCAN: begin
				idx_q <= idx_next;
				if (any_hit) begin
					found_q   <= 1'b1;
					use_src_q <= hdr_hit || pass_src;
					diff_q    <= alu_sum[31:0];
					base_q    <= by_raw ? tbl_rdata.virtual_start : tbl_rdata.raw_start;
				end
			end
			ST_FIN1: res_q <= use_src_q ? src_q : alu_sum[31:0];
			ST_FIN2: res_q <= alu_sum[31:0];
			default: ;
		endcase
	end

	//------------------------------------------------------------------
	// Ports. The result registers hold still through the reply cycle.
	//------------------------------------------------------------------
	assign busy              = (state_q != ST_IDLE);
	assign done              = (state_q == ST_REPLY);
	assign result.translated = res_q;
	assign result.found      = found_q;

	//------------------------------------------------------------------
	// Assertions.
	//------------------------------------------------------------------
	`STAT_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done,
		"accepted command did not make the block busy")
	`STAT_ASSERT_NXT(a_done_single, clk, arst_n, done, !done && !busy,
		"result strobe lasted longer than one cycle")
	`STAT_ASSERT_IMP(a_miss_zero, clk, arst_n, done && !result.found,
		result.translated == 32'd0, "miss or failed load gave a nonzero address")
	`STAT_ASSERT_IMP(a_load_timing, clk, arst_n, start && !busy && item.action == ACT_LOAD,
		##2 done, "load command did not finish two cycles after acceptance")

endmodule

[tb/stat_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the section table address translator testbench.
// Watches the APB, command and result channels; needs stat_pkg only.
module stat_result_checker #(
	parameter int MAX_SECTIONS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	input  logic                   pready,
	input  logic                   start,
	input  logic                   busy,
	input  stat_pkg::stat_item_t   item,
	input  logic                   done,
	input  stat_pkg::stat_result_t result,
	output int                     pending_results,
	output int                     mismatch_count
);
	import stat_pkg::*;

	logic [31:0]  sec_vstart [MAX_SECTIONS];
	logic [31:0]  sec_rsize  [MAX_SECTIONS];
	logic [31:0]  sec_rstart [MAX_SECTIONS];
	logic [4:0]   count_reg;
	logic [31:0]  base_reg;
	stat_result_t expected_results [$];
	int           errors;

	// First slot, in slot order, whose range holds a; the end is unwrapped at 33 bits.
	function automatic int first_containing(logic [31:0] a, bit by_raw);
		int          n;
		logic [32:0] lo;
		logic [32:0] hi;
		n = (int'(count_reg) > MAX_SECTIONS) ? MAX_SECTIONS : int'(count_reg);
		for (int i = 0; i < n; i++) begin
			lo = {1'b0, by_raw ? sec_rstart[i] : sec_vstart[i]};
			hi = lo + {1'b0, sec_rsize[i]};
			if ({1'b0, a} >= lo && {1'b0, a} < hi)
				return i;
		end
		return -1;
	endfunction

	function automatic bit map_rva(logic [31:0] rva, bit want_off, output logic [31:0] res);
		int s;
		res = rva;
		if (rva < sec_vstart[0])
			return 1'b1;
		s = first_containing(rva, 1'b0);
		if (s < 0)
			return 1'b0;
		if (want_off)
			res = rva - sec_vstart[s] + sec_rstart[s];
		return 1'b1;
	endfunction

	function automatic bit map_off(logic [31:0] off, output logic [31:0] res);
		int s;
		res = off;
		if (off < sec_rstart[0])
			return 1'b1;
		s = first_containing(off, 1'b1);
		if (s < 0)
			return 1'b0;
		res = sec_vstart[s] + (off - sec_rstart[s]);
		return 1'b1;
	endfunction

	// Applies one accepted command to the table and returns the result it must give.
	function automatic stat_result_t translate_command(stat_item_t it);
		stat_result_t r;
		logic [31:0]  v;
		bit           ok;
		v  = '0;
		ok = 1'b0;
		if (it.action == ACT_LOAD) begin
			if (int'(it.entry_index) < MAX_SECTIONS) begin
				sec_vstart[it.entry_index] = it.entry_virtual_start;
				sec_rsize[it.entry_index]  = it.entry_raw_size;
				sec_rstart[it.entry_index] = it.entry_raw_start;
				ok = 1'b1;
			end
		end else begin
			case (it.mode)
				MODE_RVA_TO_OFF: ok = map_rva(it.address, 1'b1, v);
				MODE_RVA_TO_VA: begin
					ok = map_rva(it.address, 1'b0, v);
					v  = v + base_reg;
				end
				MODE_OFF_TO_RVA: ok = map_off(it.address, v);
				MODE_OFF_TO_VA: begin
					ok = map_off(it.address, v);
					v  = v + base_reg;
				end
				MODE_VA_TO_RVA: ok = map_rva(it.address - base_reg, 1'b0, v);
				MODE_VA_TO_OFF: ok = map_rva(it.address - base_reg, 1'b1, v);
				default: ok = 1'b0;
			endcase
			if (!ok)
				v = '0;
		end
		r.translated = v;
		r.found      = ok;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stat_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_SECTIONS; i++) begin
				sec_vstart[i] = '0;
				sec_rsize[i]  = '0;
				sec_rstart[i] = '0;
			end
			count_reg = '0;
			base_reg  = '0;
			expected_results.delete();
			errors = 0;
			pending_results <= 0;
			mismatch_count  <= 0;
		end else begin
			// A result is compared before a command taken at the same edge is predicted.
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing outstanding: translated=%h found=%b",
						result.translated, result.found);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (result.translated !== want.translated) begin
						$error("translated: expected %h, actual %h",
							want.translated, result.translated);
						errors++;
					end
					if (result.found !== want.found) begin
						$error("found: expected %b, actual %b", want.found, result.found);
						errors++;
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(translate_command(item));
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_SECTION_COUNT)
					count_reg = pwdata[4:0];
				else
					base_reg = pwdata;
			end
			pending_results <= expected_results.size();
			mismatch_count  <= errors;
		end
	end

endmodule

[tb/section_table_address_translator_tb.sv]
`timescale 1ns / 1ps
// Top of the section table address translator testbench: clock, reset and stimulus.
// Depends on stat_pkg, the block itself and stat_result_checker.
module section_table_address_translator_tb;
	import stat_pkg::*;

	localparam int NUM_SLOTS    = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 32;
	localparam int PHASE_ITEMS  = 128;
	localparam int NUM_PHASES   = 8;

	logic         clk     = 1'b0;
	logic         arst_n  = 1'b0;
	logic         psel    = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite  = 1'b0;
	logic [2:0]   paddr   = '0;
	logic [31:0]  pwdata  = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         start   = 1'b0;
	logic         busy;
	stat_item_t   item    = '0;
	logic         done;
	stat_result_t result;
	int           pending_results;
	int           mismatch_count;

	// The stimulus keeps its own view of what it has loaded, only to aim addresses at
	// section edges and to make sure no translate ever reads a slot never loaded.
	logic [31:0]  aim_vstart [NUM_SLOTS];
	logic [31:0]  aim_rsize  [NUM_SLOTS];
	logic [31:0]  aim_rstart [NUM_SLOTS];
	bit           aim_loaded [NUM_SLOTS];
	logic [4:0]   cur_count;
	logic [31:0]  cur_base;
	int           burst_left;
	bit           steady;
	int           cycles;

	section_table_address_translator #(
		.MAX_SECTIONS(NUM_SLOTS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result)
	);

	stat_result_checker #(
		.MAX_SECTIONS(NUM_SLOTS)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.start           (start),
		.busy            (busy),
		.item            (item),
		.done            (done),
		.result          (result),
		.pending_results (pending_results),
		.mismatch_count  (mismatch_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The watchdog ends a run that hangs, for example when a result never comes.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("section_table_address_translator: mismatch");
		$finish;
	end

	// One APB write: a setup cycle, then an access cycle held until pready. The bus then
	// goes idle before the task returns, so a following write never raises psel in the step that lowers it.
	task automatic write_reg(logic sel, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (sel == REG_SECTION_COUNT)
			cur_count = value[4:0];
		else
			cur_base = value;
	endtask

	// Holds the command on the channel until the edge at which busy is low, which
	// is the edge of the transfer. Signals read just after an edge hold their values
	// from before it, since the block and the checker update theirs nonblocking.
	task automatic send_command(stat_item_t it);
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (it.action == ACT_LOAD && int'(it.entry_index) < NUM_SLOTS) begin
			aim_vstart[it.entry_index] = it.entry_virtual_start;
			aim_rsize[it.entry_index]  = it.entry_raw_size;
			aim_rstart[it.entry_index] = it.entry_raw_start;
			aim_loaded[it.entry_index] = 1'b1;
		end
	endtask

	// Sender pacing: bursts of random length, separated by random gaps. In a steady
	// phase commands go back to back for the whole phase.
	task automatic pace();
		int gap;
		if (steady)
			return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stops sending and waits until every expected result has arrived and the block
	// is idle, so that registers may be written.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results != 0 || busy)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic stat_item_t make_item(logic act, logic [2:0] md, logic [31:0] addr,
			logic [3:0] idx, logic [31:0] vs, logic [31:0] sz, logic [31:0] rs);
		stat_item_t it;
		it.action              = act;
		it.mode                = md;
		it.address             = addr;
		it.entry_index         = idx;
		it.entry_virtual_start = vs;
		it.entry_raw_size      = sz;
		it.entry_raw_start     = rs;
		return it;
	endfunction

	// Mostly translates aimed at the edges of a loaded section, with loads laid out
	// like a real image (ascending starts, modest sizes) and some wild values mixed in.
	// A translate that would read a never-loaded slot becomes a load of that slot.
	function automatic stat_item_t random_command();
		stat_item_t  it;
		int          act;
		int          need;
		int          s;
		logic [31:0] lo;
		logic [31:0] sz;
		logic [31:0] addr;
		bit          by_raw;
		it.action              = ACT_XLATE;
		it.mode                = 3'($urandom_range(0, 7));
		it.address             = $urandom;
		it.entry_index         = 4'($urandom_range(0, 15));
		it.entry_virtual_start = $urandom;
		it.entry_raw_size      = $urandom;
		it.entry_raw_start     = $urandom;
		act  = (int'(cur_count) > NUM_SLOTS) ? NUM_SLOTS : int'(cur_count);
		need = -1;
		for (int i = (act > 0 ? act : 1) - 1; i >= 0; i--)
			if (!aim_loaded[i])
				need = i;
		if (need >= 0 || $urandom_range(0, 3) == 0) begin
			it.action = ACT_LOAD;
			if (need >= 0)
				it.entry_index = 4'(need);
			if ($urandom_range(0, 7) != 0)
				it.entry_virtual_start = ((int'(it.entry_index) + 1) << 16)
					| $urandom_range(0, 32'h3FFF);
			if ($urandom_range(0, 7) != 0)
				it.entry_raw_start = ((int'(it.entry_index) + 1) << 14)
					| $urandom_range(0, 32'h0FFF);
			case ($urandom_range(0, 7))
				0: it.entry_raw_size = $urandom;
				1: it.entry_raw_size = '0;
				default: it.entry_raw_size = $urandom_range(1, 32'h8000);
			endcase
		end else begin
			if ($urandom_range(0, 15) == 0)
				it.mode = 3'($urandom_range(6, 7));
			else
				it.mode = 3'($urandom_range(0, 5));
			by_raw = (it.mode == MODE_OFF_TO_RVA || it.mode == MODE_OFF_TO_VA);
			s  = (act == 0) ? 0 : $urandom_range(0, act - 1);
			lo = by_raw ? aim_rstart[s] : aim_vstart[s];
			sz = aim_rsize[s];
			case ($urandom_range(0, 5))
				0: addr = lo;
				1: addr = lo + sz - 1;
				2: addr = lo + sz;
				3: addr = lo - 1;
				4: addr = lo + ((sz == 0) ? 32'd0 : ($urandom % sz));
				default: addr = $urandom;
			endcase
			if (it.mode == MODE_VA_TO_RVA || it.mode == MODE_VA_TO_OFF)
				addr = addr + cur_base;
			it.address = addr;
		end
		return it;
	endfunction

	initial begin
		logic [4:0]  phase_count [NUM_PHASES];
		logic [31:0] phase_base  [NUM_PHASES];
		int          pause_at;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			aim_vstart[i] = '0;
			aim_rsize[i]  = '0;
			aim_rstart[i] = '0;
			aim_loaded[i] = 1'b0;
		end
		cur_count  = '0;
		cur_base   = '0;
		burst_left = 0;
		steady     = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Four sections: two small ones, one whose end only fits in 33
		// bits, and an all-ones entry of size zero that can never be hit.
		write_reg(REG_SECTION_COUNT, 32'd4);
		write_reg(REG_IMAGE_BASE, 32'h0040_0000);
		send_command(make_item(ACT_LOAD, 3'd0, 32'h0, 4'd0, 32'h1000, 32'h200, 32'h400));
		pace();
		send_command(make_item(ACT_LOAD, 3'd0, 32'h0, 4'd1, 32'h2000, 32'h1000, 32'h600));
		pace();
		send_command(make_item(ACT_LOAD, 3'd0, 32'h0, 4'd2,
			32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FF00));
		pace();
		// A load ignores its mode and address fields, so junk goes there.
		send_command(make_item(ACT_LOAD, 3'd7, 32'hFFFF_FFFF, 4'd3,
			32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
		pace();
		// Header, last byte of a section, one past it, and every mode once or more.
		send_command(make_item(ACT_XLATE, MODE_RVA_TO_OFF, 32'h0, 4'd0, '0, '0, '0));
		pace();
		send_command(make_item(ACT_XLATE, MODE_RVA_TO_OFF, 32'h11FF, 4'd0, '0, '0, '0));
		pace();
		send_command(make_item(ACT_XLATE, MODE_RVA_TO_OFF, 32'h1200, 4'd0, '0, '0, '0));
		pace();
		send_command(make_item(ACT_XLATE, MODE_RVA_TO_VA, 32'h2FFF, 4'd0, '0, '0, '0));
		pace();
		send_command(make_item(ACT_XLATE, MODE_OFF_TO_RVA, 32'h3FF, 4'd0, '0, '0, '0));
		pace();
		send_command(make_item(ACT_XLATE, MODE_OFF_TO_RVA, 32'h500, 4'd0, '0, '0, '0));
		pace();
		send_command(make_item(ACT_XLATE, MODE_OFF_TO_VA, 32'h1000, 4'd0, '0, '0, '0));
		pace();
		send_command(make_item(ACT_XLATE, MODE_VA_TO_RVA, 32'h0040_2010, 4'd0, '0, '0, '0));
		pace();
		// A VA below the image base wraps when the base is taken off.
		send_command(make_item(ACT_XLATE, MODE_VA_TO_RVA, 32'h0, 4'd0, '0, '0, '0));
		pace();
		// VA to offset inside the header gives the RVA unchanged.
		send_command(make_item(ACT_XLATE, MODE_VA_TO_OFF, 32'h0040_0010, 4'd0, '0, '0, '0));
		pace();
		send_command(make_item(ACT_XLATE, MODE_VA_TO_OFF, 32'h003F_F800, 4'd0, '0, '0, '0));
		pace();
		send_command(make_item(ACT_XLATE, MODE_RVA_TO_OFF, 32'hFFFF_FFFF, 4'd0, '0, '0, '0));
		pace();
		send_command(make_item(ACT_XLATE, MODE_OFF_TO_RVA, 32'hFFFF_FFFF, 4'd0, '0, '0, '0));
		pace();
		send_command(make_item(ACT_XLATE, MODE_RVA_TO_VA, 32'hFFFF_FFFF, 4'd0, '0, '0, '0));
		pace();
		// The two codes past the last mode must miss.
		send_command(make_item(ACT_XLATE, 3'd6, 32'h1100, 4'd0, '0, '0, '0));
		pace();
		send_command(make_item(ACT_XLATE, 3'd7, 32'h1100, 4'd0, '0, '0, '0));
		wait_idle();
		// With no sections searched, only the header check can hit.
		write_reg(REG_SECTION_COUNT, 32'd0);
		send_command(make_item(ACT_XLATE, MODE_RVA_TO_OFF, 32'h10, 4'd0, '0, '0, '0));
		pace();
		send_command(make_item(ACT_XLATE, MODE_RVA_TO_OFF, 32'h1100, 4'd0, '0, '0, '0));
		wait_idle();

		// Random part: several register settings, extremes included. A count above
		// the table size must behave as a full table.
		phase_count = '{5'd16, 5'd0, 5'd1, 5'd31, 5'($urandom_range(2, 15)), 5'd16,
			5'($urandom_range(0, 16)), 5'd16};
		phase_base  = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom, 32'h0040_0000,
			32'hFFFF_F000, $urandom, 32'h1000_0000};
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_reg(REG_SECTION_COUNT, {27'd0, phase_count[p]});
			write_reg(REG_IMAGE_BASE, phase_base[p]);
			steady   = (p == 2 || p == 6);
			pause_at = $urandom_range(10, PHASE_ITEMS - 10);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_command(random_command());
				// Once per phase the sender holds off until the block has drained.
				if (n == pause_at)
					wait_idle();
				else
					pace();
			end
			wait_idle();
		end

		// Give a stray result time to show before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("section_table_address_translator: match");
		else
			$display("section_table_address_translator: mismatch");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/stat_pkg.sv
rtl/stat_alu.sv
rtl/stat_table.sv
rtl/section_table_address_translator.sv
tb/stat_result_checker.sv
tb/section_table_address_translator_tb.sv
